FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the pitch shifter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop holds at every clock edge outside reset
`define DHPS_ASSERT_HOLD(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("dhps assertion failed");

// ante implies cons in the same cycle
`define DHPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dhps assertion failed");

// ante implies cons in the next cycle
`define DHPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dhps assertion failed");

`else

`define DHPS_ASSERT_HOLD(label, clk, rst, prop)
`define DHPS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DHPS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/dhps_pkg.sv
// ----------------------------------------------------------------------------
// dhps_pkg
// Constants and types shared by the dual head pitch shifter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dhps_pkg;

   // delay store geometry (depth must be a power of two)
   localparam int STORE_DEPTH   = 4096;
   localparam int FRACTION_BITS = 16;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int POS_W         = ADDR_W + FRACTION_BITS;

   localparam int SAMPLE_W = 32;
   localparam int DIFF_W   = SAMPLE_W + 1;

   // unsigned Q1.16 crossfade weight, 0..65536
   localparam int WEIGHT_BITS = 16;
   localparam int WEIGHT_W    = WEIGHT_BITS + 1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = {1'b1, {WEIGHT_BITS{1'b0}}};

   // shared multiplier: signed difference times unsigned weight or fraction
   localparam int MULW_W = (FRACTION_BITS > WEIGHT_W) ? FRACTION_BITS : WEIGHT_W;
   localparam int PROD_W = DIFF_W + MULW_W + 1;

   // pitch step register, unsigned 2.16
   localparam int PITCH_W = 18;
   localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(65536);
   localparam int STEP_UP = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
   localparam int STEP_DN = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
   localparam int STEP_W  = PITCH_W + STEP_UP;

   // STORE_DEPTH in head format, and half of it
   localparam logic [POS_W:0]   DEPTH_FX = {1'b1, {POS_W{1'b0}}};
   localparam logic [POS_W-1:0] HALF_FX  = {1'b1, {(POS_W-1){1'b0}}};

   localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(STORE_DEPTH - 1);

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic [ADDR_W-1:0]        wr_addr;
      logic [ADDR_W-1:0]        h1_lo;
      logic [ADDR_W-1:0]        h1_hi;
      logic [FRACTION_BITS-1:0] h1_frac;
      logic [ADDR_W-1:0]        h2_lo;
      logic [ADDR_W-1:0]        h2_hi;
      logic [FRACTION_BITS-1:0] h2_frac;
      logic [WEIGHT_W-1:0]      fade1;
   } ptr_type;

endpackage

`default_nettype wire

FILE: rtl/dhps_channels.sv
// ----------------------------------------------------------------------------
// dhps channels
// Valid/ready channel interfaces for samples, results and the step register.
// ----------------------------------------------------------------------------
`default_nettype none

interface dhps_sample_if;
   logic                              valid;
   logic                              ready;
   logic [dhps_pkg::SAMPLE_W-1:0]     in_sample;

   modport source (output valid, output in_sample, input ready);
   modport sink   (input valid, input in_sample, output ready);
endinterface

interface dhps_result_if;
   logic                              valid;
   logic                              ready;
   logic [dhps_pkg::SAMPLE_W-1:0]     shifted_sample;

   modport source (output valid, output shifted_sample, input ready);
   modport sink   (input valid, input shifted_sample, output ready);
endinterface

interface dhps_csr_if;
   logic                              valid;
   logic                              ready;
   logic [dhps_pkg::PITCH_W-1:0]      pitch_step;

   modport source (output valid, output pitch_step, input ready);
   modport sink   (input valid, input pitch_step, output ready);
endinterface

`default_nettype wire

FILE: rtl/dhps_delay_store.sv
// ----------------------------------------------------------------------------
// dhps_delay_store
// Circular sample store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module dhps_delay_store (
   input  wire logic                               clock,
   input  wire dhps_pkg::store_wr_type             wr,
   input  wire logic [dhps_pkg::ADDR_W-1:0]        rd_a_addr,
   input  wire logic [dhps_pkg::ADDR_W-1:0]        rd_b_addr,
   output logic      [dhps_pkg::SAMPLE_W-1:0]      rd_a_data,
   output logic      [dhps_pkg::SAMPLE_W-1:0]      rd_b_data
);

   logic [dhps_pkg::SAMPLE_W-1:0] mem [dhps_pkg::STORE_DEPTH];
   logic [dhps_pkg::SAMPLE_W-1:0] rd_a_ff;
   logic [dhps_pkg::SAMPLE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

FILE: rtl/dhps_pointer_unit.sv
// ----------------------------------------------------------------------------
// dhps_pointer_unit
// Write index, two read heads, pitch step register and crossfade weight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dhps_pointer_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [dhps_pkg::PITCH_W-1:0]   csr_data,
   input  wire logic                           advance,
   output dhps_pkg::ptr_type                   ptr
);

   logic [dhps_pkg::PITCH_W-1:0]  pitch_ff;
   logic [dhps_pkg::ADDR_W-1:0]   wi_ff;
   logic [dhps_pkg::POS_W-1:0]    h1_ff;
   logic [dhps_pkg::POS_W-1:0]    h2_ff;
   logic [dhps_pkg::POS_W-1:0]    dist_ff;
   logic [dhps_pkg::POS_W-1:0]    dist_in;
   logic [dhps_pkg::WEIGHT_W-1:0] fade_ff;
   logic [dhps_pkg::WEIGHT_W-1:0] fade_in;
   logic [dhps_pkg::POS_W-1:0]    step_fx;
   logic [dhps_pkg::POS_W:0]      twice;
   logic [dhps_pkg::POS_W:0]      away;
   logic [dhps_pkg::POS_W:0]      closeness;
   logic [dhps_pkg::POS_W+dhps_pkg::WEIGHT_BITS:0] scaled;

   // 2.16 step aligned to the head fraction width
   assign step_fx = dhps_pkg::POS_W'(
      (dhps_pkg::STEP_W'(pitch_ff) << dhps_pkg::STEP_UP) >> dhps_pkg::STEP_DN);

   // head one's distance behind the write index, modulo the store
   assign dist_in = {wi_ff, {dhps_pkg::FRACTION_BITS{1'b0}}} - h1_ff;

   // triangle window: 1 - |2*dist/N - 1|, scaled by 2^16 / N (a bit slice)
   always_comb begin
      twice = {dist_ff, 1'b0};
      if (twice >= dhps_pkg::DEPTH_FX) begin
         away = twice - dhps_pkg::DEPTH_FX;
      end else begin
         away = dhps_pkg::DEPTH_FX - twice;
      end
      closeness = dhps_pkg::DEPTH_FX - away;
      scaled    = {closeness, {dhps_pkg::WEIGHT_BITS{1'b0}}};
      fade_in   = scaled[dhps_pkg::POS_W+dhps_pkg::WEIGHT_BITS:dhps_pkg::POS_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= dhps_pkg::PITCH_RESET;
         wi_ff    <= '0;
         h1_ff    <= '0;
         h2_ff    <= dhps_pkg::HALF_FX;
         dist_ff  <= '0;
         fade_ff  <= '0;
      end else begin
         if (csr_we) begin
            pitch_ff <= csr_data;
         end
         if (advance) begin
            wi_ff <= wi_ff + dhps_pkg::ADDR_W'(1);
            // power-of-two store: the wrap is the carry out
            h1_ff <= h1_ff + step_fx;
            h2_ff <= h2_ff + step_fx;
         end
         dist_ff <= dist_in;
         fade_ff <= fade_in;
      end
   end

   always_comb begin
      ptr.wr_addr = wi_ff;
      ptr.h1_lo   = h1_ff[dhps_pkg::POS_W-1:dhps_pkg::FRACTION_BITS];
      ptr.h1_hi   = h1_ff[dhps_pkg::POS_W-1:dhps_pkg::FRACTION_BITS] + dhps_pkg::ADDR_W'(1);
      ptr.h1_frac = h1_ff[dhps_pkg::FRACTION_BITS-1:0];
      ptr.h2_lo   = h2_ff[dhps_pkg::POS_W-1:dhps_pkg::FRACTION_BITS];
      ptr.h2_hi   = h2_ff[dhps_pkg::POS_W-1:dhps_pkg::FRACTION_BITS] + dhps_pkg::ADDR_W'(1);
      ptr.h2_frac = h2_ff[dhps_pkg::FRACTION_BITS-1:0];
      ptr.fade1   = fade_ff;
   end

   // heads always stay half a store apart
   `DHPS_ASSERT_HOLD(a_head_gap, clock, reset, dhps_pkg::POS_W'(h2_ff - h1_ff) == dhps_pkg::HALF_FX)
   // weight never exceeds one
   `DHPS_ASSERT_HOLD(a_fade_range, clock, reset, fade_ff <= dhps_pkg::WEIGHT_ONE)

endmodule

`default_nettype wire

FILE: rtl/dual_head_pitch_shifter_unit.sv
// ----------------------------------------------------------------------------
// dual_head_pitch_shifter_unit
// Two-head delay-line pitch shifter with triangle crossfade.
// ----------------------------------------------------------------------------
// Each accepted sample is written into a 4096-entry circular store; two
// fractional read heads, half a store apart, advance by pitch_step (2.16) per
// sample. Each head reads its floor and next entries (both ports of the store
// at once) and interpolates linearly; the two reads are blended with triangle
// weights fade1 = 1 - |2*dist/N - 1| and fade2 = 1 - fade1, where dist is head
// one's distance behind the write index. A sample is taken only in ST_IDLE,
// then the sequencer runs eight steps (ST_RD1 to ST_DONE) before the next
// one: one shared 33x17 multiplier is used three times per sample (two
// interpolations, one blend), each product registered before the add,
// behind two store reads. The result sits in an output register, so the next
// sample is accepted while the previous result waits for its transfer. After
// reset the store is cleared one entry a cycle, while no sample is taken;
// pitch_step writes are taken at any time and should only be made while the
// block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dual_head_pitch_shifter_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   dhps_sample_if.sink     req_bus,
   dhps_result_if.source   rsp_bus,
   dhps_csr_if.sink        csr_bus
);

   typedef enum logic [3:0] {
      ST_CLEAR,   // zeroing the store after reset
      ST_IDLE,    // waiting for a sample transfer
      ST_RD1,     // read head one's pair
      ST_RD2,     // read head two's pair, capture head one's pair
      ST_CAP2,    // capture head two's pair, multiply head one
      ST_LERP1,   // finish head one, multiply head two
      ST_LERP2,   // finish head two
      ST_BDIF,    // blend difference
      ST_BMUL,    // blend multiply
      ST_DONE     // blend add, hand to output register
   } state_type;

   state_type                          state_ff;
   logic [dhps_pkg::ADDR_W-1:0]        clr_ff;

   dhps_pkg::store_wr_type             store_wr;
   dhps_pkg::ptr_type                  ptr;
   logic [dhps_pkg::ADDR_W-1:0]        rd_a_addr;
   logic [dhps_pkg::ADDR_W-1:0]        rd_b_addr;
   logic [dhps_pkg::SAMPLE_W-1:0]      rd_a_data;
   logic [dhps_pkg::SAMPLE_W-1:0]      rd_b_data;

   // datapath registers
   logic [dhps_pkg::SAMPLE_W-1:0]      base1_ff;
   logic [dhps_pkg::SAMPLE_W-1:0]      base2_ff;
   logic [dhps_pkg::DIFF_W-1:0]        diff1_ff;   // also holds v1 - v2
   logic [dhps_pkg::DIFF_W-1:0]        diff2_ff;
   logic signed [dhps_pkg::PROD_W-1:0] prod_ff;
   logic [dhps_pkg::SAMPLE_W-1:0]      v1_ff;
   logic [dhps_pkg::SAMPLE_W-1:0]      v2_ff;

   // output register
   logic                               rsp_valid_ff;
   logic [dhps_pkg::SAMPLE_W-1:0]      rsp_data_ff;

   logic                               accept;
   logic                               out_free;
   logic                               advance;
   logic [dhps_pkg::DIFF_W-1:0]        diff_in;
   logic [dhps_pkg::DIFF_W-1:0]        bdiff_in;
   logic [dhps_pkg::DIFF_W-1:0]        mul_a;
   logic [dhps_pkg::MULW_W-1:0]        mul_w;
   logic signed [dhps_pkg::PROD_W-1:0] prod_in;
   logic signed [dhps_pkg::PROD_W-1:0] lerp_shift;
   logic signed [dhps_pkg::PROD_W-1:0] blend_shift;
   logic [dhps_pkg::SAMPLE_W-1:0]      add_base;
   logic [dhps_pkg::SAMPLE_W-1:0]      add_term;
   logic [dhps_pkg::SAMPLE_W-1:0]      add_out;

   // ---------------- handshakes ----------------
   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign accept         = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.shifted_sample = rsp_data_ff;
   assign out_free       = !rsp_valid_ff || rsp_bus.ready;
   assign advance        = (state_ff == ST_DONE) && out_free;
   assign csr_bus.ready  = 1'b1;

   // ---------------- store ports ----------------
   // The sample goes in at the accept edge; the heads read from ST_RD1 on,
   // so a head sitting on the write index sees the new sample.
   always_comb begin
      store_wr.en   = (state_ff == ST_CLEAR) || accept;
      store_wr.addr = (state_ff == ST_CLEAR) ? clr_ff : ptr.wr_addr;
      store_wr.data = (state_ff == ST_CLEAR) ? '0 : req_bus.in_sample;
   end

   always_comb begin
      case (state_ff)
         ST_RD1: begin
            rd_a_addr = ptr.h1_lo;
            rd_b_addr = ptr.h1_hi;
         end
         default: begin
            rd_a_addr = ptr.h2_lo;
            rd_b_addr = ptr.h2_hi;
         end
      endcase
   end

   dhps_delay_store u_store (
      .clock     (clock),
      .wr        (store_wr),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   dhps_pointer_unit u_ptr (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_bus.valid && csr_bus.ready),
      .csr_data (csr_bus.pitch_step),
      .advance  (advance),
      .ptr      (ptr)
   );

   // ---------------- arithmetic ----------------
   // lerp: a + floor((b - a) * f / 2^F)
   // blend: v2 + floor((v1 - v2) * fade1 / 2^16)
   // Both land between their two inputs, so 32-bit wraparound adds are exact
   // and the result can never need saturation.
   assign diff_in  = {rd_b_data[dhps_pkg::SAMPLE_W-1], rd_b_data}
                   - {rd_a_data[dhps_pkg::SAMPLE_W-1], rd_a_data};
   assign bdiff_in = {v1_ff[dhps_pkg::SAMPLE_W-1], v1_ff}
                   - {v2_ff[dhps_pkg::SAMPLE_W-1], v2_ff};

   always_comb begin
      case (state_ff)
         ST_CAP2: begin
            mul_a = diff1_ff;
            mul_w = dhps_pkg::MULW_W'(ptr.h1_frac);
         end
         ST_LERP1: begin
            mul_a = diff2_ff;
            mul_w = dhps_pkg::MULW_W'(ptr.h2_frac);
         end
         default: begin
            mul_a = diff1_ff;
            mul_w = dhps_pkg::MULW_W'(ptr.fade1);
         end
      endcase
   end

   assign prod_in     = $signed(mul_a) * $signed({1'b0, mul_w});
   assign lerp_shift  = prod_ff >>> dhps_pkg::FRACTION_BITS;
   assign blend_shift = prod_ff >>> dhps_pkg::WEIGHT_BITS;

   always_comb begin
      case (state_ff)
         ST_LERP1: begin
            add_base = base1_ff;
            add_term = lerp_shift[dhps_pkg::SAMPLE_W-1:0];
         end
         ST_LERP2: begin
            add_base = base2_ff;
            add_term = lerp_shift[dhps_pkg::SAMPLE_W-1:0];
         end
         default: begin
            add_base = v2_ff;
            add_term = blend_shift[dhps_pkg::SAMPLE_W-1:0];
         end
      endcase
   end

   assign add_out = add_base + add_term;

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result refills the output register in the cycle it drains
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + dhps_pkg::ADDR_W'(1);
               if (clr_ff == dhps_pkg::CLEAR_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_RD1;
               end
            end
            ST_RD1: begin
               state_ff <= ST_RD2;
            end
            ST_RD2: begin
               base1_ff <= rd_a_data;
               diff1_ff <= diff_in;
               state_ff <= ST_CAP2;
            end
            ST_CAP2: begin
               base2_ff <= rd_a_data;
               diff2_ff <= diff_in;
               prod_ff  <= prod_in;
               state_ff <= ST_LERP1;
            end
            ST_LERP1: begin
               v1_ff    <= add_out;
               prod_ff  <= prod_in;
               state_ff <= ST_LERP2;
            end
            ST_LERP2: begin
               v2_ff    <= add_out;
               state_ff <= ST_BDIF;
            end
            ST_BDIF: begin
               diff1_ff <= bdiff_in;
               state_ff <= ST_BMUL;
            end
            ST_BMUL: begin
               prod_ff  <= prod_in;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               // hold here while the previous result still waits
               if (out_free) begin
                  rsp_data_ff  <= add_out;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

   // a sample transfer always starts the read sequence
   `DHPS_ASSERT_NEXT(a_accept_starts, clock, reset, accept, state_ff == ST_RD1)
   // a finished blend reaches the output register and frees the engine
   `DHPS_ASSERT_NEXT(a_done_delivers, clock, reset, advance, rsp_valid_ff && (state_ff == ST_IDLE))
   // outside the clearing pass the store is written only by a sample transfer
   `DHPS_ASSERT_IMPL(a_store_write, clock, reset, store_wr.en && (state_ff != ST_CLEAR), accept)

endmodule

`default_nettype wire

FILE: bench/dual_head_pitch_shifter_unit_checker.sv
// ----------------------------------------------------------------------------
// dual_head_pitch_shifter_unit_checker
// Watches the sample, result and step channels and checks every result
// transfer against its own fixed-point model of the two-head shifter.
// ----------------------------------------------------------------------------
module dual_head_pitch_shifter_unit_checker (
   input  wire logic clock,
   input  wire logic reset,
   dhps_sample_if    req_mon,
   dhps_result_if    rsp_mon,
   dhps_csr_if       csr_mon,
   output int        mismatch_count,
   output int        pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import dhps_pkg::*;

   localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_W - 1));
   localparam int     REPORT_MAX = 10;

   // model state
   logic signed [SAMPLE_W-1:0] delay_copy [STORE_DEPTH];
   logic [ADDR_W-1:0]          wr_ptr;
   logic [POS_W-1:0]           head_a;
   logic [POS_W-1:0]           head_b;
   logic [PITCH_W-1:0]         step_reg;
   logic [SAMPLE_W-1:0]        shifted_due [$];

   // linear interpolation between the floor entry and the next one
   function automatic longint interp_read(input logic [POS_W-1:0] pos);
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      longint            f;
      longint            a;
      longint            b;
      lo = pos[POS_W-1:FRACTION_BITS];
      hi = lo + 1'b1;
      f  = longint'(pos[FRACTION_BITS-1:0]);
      a  = delay_copy[lo];
      b  = delay_copy[hi];
      return (a * (longint'(1) << FRACTION_BITS) - a * f + b * f) >>> FRACTION_BITS;
   endfunction

   // store one sample, blend both heads, advance pointers
   function automatic logic [SAMPLE_W-1:0] shift_one_sample(
      input logic [SAMPLE_W-1:0] raw
   );
      logic [POS_W-1:0] lag;
      logic [POS_W:0]   twice;
      logic [POS_W:0]   away;
      longint           fade1;
      longint           fade2;
      longint           v1;
      longint           v2;
      longint           y;
      longint           advance;
      delay_copy[wr_ptr] = raw;
      // distance wraps modulo the store size in head format
      lag   = (POS_W'(wr_ptr) << FRACTION_BITS) - head_a;
      twice = {lag, 1'b0};
      away  = (twice >= DEPTH_FX) ? twice - DEPTH_FX : DEPTH_FX - twice;
      fade1 = ((longint'(DEPTH_FX) - longint'(away)) << WEIGHT_BITS) / longint'(DEPTH_FX);
      fade2 = longint'(WEIGHT_ONE) - fade1;
      v1 = interp_read(head_a);
      v2 = interp_read(head_b);
      y  = (v1 * fade1 + v2 * fade2) >>> WEIGHT_BITS;
      if (y > SAMPLE_MAX) y = SAMPLE_MAX;
      if (y < SAMPLE_MIN) y = SAMPLE_MIN;
      wr_ptr  = wr_ptr + 1'b1;
      advance = (longint'(step_reg) << STEP_UP) >> STEP_DN;
      // store depth is a power of two: head wrap is the natural overflow
      head_a = head_a + POS_W'(advance);
      head_b = head_b + POS_W'(advance);
      return y[SAMPLE_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) delay_copy[i] = '0;
         wr_ptr   = '0;
         head_a   = '0;
         head_b   = HALF_FX;
         step_reg = PITCH_RESET;
         shifted_due.delete();
         mismatch_count = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) step_reg = csr_mon.pitch_step;
         // results first: a result never belongs to a sample taken this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (shifted_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: unexpected result %0d", $realtime,
                           $signed(rsp_mon.shifted_sample));
            end else begin
               if (rsp_mon.shifted_sample !== shifted_due[0]) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display("%0t: shifted_sample expected %0d, got %0d", $realtime,
                              $signed(shifted_due[0]), $signed(rsp_mon.shifted_sample));
               end
               void'(shifted_due.pop_front());
            end
         end
         if (req_mon.valid && req_mon.ready)
            shifted_due.push_back(shift_one_sample(req_mon.in_sample));
      end
      pending_count = shifted_due.size();
   end

endmodule

FILE: bench/dual_head_pitch_shifter_unit_tb.sv
// ----------------------------------------------------------------------------
// dual_head_pitch_shifter_unit_tb
// Drives samples and pitch steps into the shifter with random gaps and
// result stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module dual_head_pitch_shifter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dhps_pkg::*;

   // the store clear after reset, the sequencer steps of each sample, plus
   // random gaps and stalls: this limit covers them several times over
   localparam int CYCLE_LIMIT   = 200000;
   // extra wait after the last result transfer, with some slack
   localparam int SETTLE_CYCLES = 16;
   localparam logic [PITCH_W-1:0] PITCH_MAX = {PITCH_W{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatch_count;
   int   pending_count;
   int   cycle_count = 0;
   bit   calm = 1'b0;   // set for the last phase: no gaps, no stalls

   dhps_sample_if req_bus ();
   dhps_result_if rsp_bus ();
   dhps_csr_if    csr_bus ();

   dual_head_pitch_shifter_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   dual_head_pitch_shifter_unit_checker result_watch (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("dual_head_pitch_shifter_unit_tb failed");
         $finish;
      end
   end

   // Mostly full-range noise, some quiet signal, some rail values so the
   // blend sees both saturation corners.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
               1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
               2: return '1;
               default: return '0;
            endcase
         end
         1, 2: return SAMPLE_W'($urandom_range(0, 511)) - SAMPLE_W'(256);
         default: return $urandom();
      endcase
   endfunction

   // One sample transfer. Valid is only dropped ahead of a gap, so it is
   // never lowered and raised in the same step.
   task automatic push_sample(input logic [SAMPLE_W-1:0] value);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.in_sample = value;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Stop sending and hold off until every result has been transferred.
   task automatic drain();
      req_bus.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Step register write; only called with the block idle.
   task automatic write_pitch(input logic [PITCH_W-1:0] step);
      csr_bus.valid      = 1'b1;
      csr_bus.pitch_step = step;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic random_run(input int count);
      repeat (count) push_sample(pick_sample());
   endtask

   // result side: bursts of stall between stretches of ready
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end else begin
            rsp_bus.ready = 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clock);
         end
      end
   end

   initial begin
      logic [SAMPLE_W-1:0] opening [$];
      req_bus.valid      = 1'b0;
      req_bus.in_sample  = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.pitch_step = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Directed, at the reset step of 1.0. Head one starts on the write
      // index, so the first samples are read back as soon as written.
      // Rails, sign boundaries, bit patterns, then rail swings for the blend.
      opening = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE, 32'hAAAA_AAAA,
                  32'h5555_5555, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_0000};
      foreach (opening[i]) push_sample(opening[i]);

      // frozen heads: only the write index moves, so the weights sweep
      drain();
      write_pitch('0);
      random_run(25);

      // slow-down ratio below 1.0
      drain();
      write_pitch(PITCH_W'($urandom_range(1, 65535)));
      random_run(25);

      // fastest step, just under 4.0; takes head two up near the top
      drain();
      write_pitch(PITCH_MAX);
      random_run(500);

      // back to 1.0 with no idling: head two crosses the last entry, where
      // its next entry wraps to 0, and then wraps itself
      drain();
      write_pitch(PITCH_RESET);
      calm = 1'b1;
      random_run(60);

      drain();
      if (mismatch_count == 0) begin
         $display("dual_head_pitch_shifter_unit_tb passed");
      end else begin
         $display("dual_head_pitch_shifter_unit_tb failed");
      end
      $finish;
   end

endmodule
